[sv/ipp_pkg.sv]
// Shared types and codes for the IP address text parser.
// No dependencies; imported by ipp_front, ipp_back, the top level and ipp_checker.
`default_nettype none

package ipp_pkg;

	localparam int IPP_QDEPTH = 4;

	// address family codes on the input tuser
	localparam logic [1:0] FAM_V4 = 2'd0;
	localparam logic [1:0] FAM_V6 = 2'd1;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_UNSUP   = 2'd2
	} ipp_status_t;

	// one classified character
	typedef struct packed {
		logic       nul;
		logic       colon;
		logic       dot;
		logic       is_dec;
		logic       is_hex;
		logic [3:0] val;
		logic [1:0] fam;
	} ipp_tok_t;

endpackage

`default_nettype wire

[sv/ipp_front.sv]
// Input side: accepts characters and classifies them into tokens.
// Depends on ipp_pkg.
`default_nettype none

module ipp_front
	import ipp_pkg::*;
(
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // ch
	input  wire logic [1:0] s_tuser,   // func
	input  wire logic       full,
	output logic            push,
	output ipp_tok_t        tok
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOT   = 8'h2e;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		tok       = '0;
		tok.fam   = s_tuser;
		tok.nul   = (s_tdata == CH_NUL);
		tok.colon = (s_tdata == CH_COLON);
		tok.dot   = (s_tdata == CH_DOT);
		if (s_tdata >= CH_0 && s_tdata <= CH_9) begin
			tok.is_dec = 1'b1;
			tok.is_hex = 1'b1;
			tok.val    = 4'(s_tdata - CH_0);
		end else if (s_tdata >= CH_LA && s_tdata <= CH_LF) begin
			tok.is_hex = 1'b1;
			tok.val    = 4'(s_tdata - CH_LA + 8'd10);
		end else if (s_tdata >= CH_UA && s_tdata <= CH_UF) begin
			tok.is_hex = 1'b1;
			tok.val    = 4'(s_tdata - CH_UA + 8'd10);
		end
	end

endmodule

`default_nettype wire

[sv/ipp_queue.sv]
// Short token queue between the classifier and the parser.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module ipp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/ipp_back.sv]
// Parser sequencer: consumes tokens, builds the address, expands the gap
// and drives the result register. Depends on ipp_pkg.
`default_nettype none

module ipp_back
	import ipp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tok_valid,
	input  wire ipp_tok_t    tok,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [127:0]     m_tdata,  // addr_high, addr_low
	output logic [1:0]       m_tuser   // status
);

	typedef enum logic {
		ST_RUN,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_V4,
		M_V6,
		M_QUAD,
		M_UNSUP
	} mode_t;

	state_t      state_q, state_d;
	mode_t       mode_q, mode_d;
	logic        err_q, err_d;
	logic        lcp_q, lcp_d;
	logic [7:0]  bytes_q [16];
	logic [7:0]  bytes_d [16];
	logic [4:0]  wp_q, wp_d;
	logic [4:0]  gap_pos_q, gap_pos_d;
	logic        gap_seen_q, gap_seen_d;
	logic [15:0] hex_acc_q, hex_acc_d;
	logic        saw_hex_q, saw_hex_d;
	logic [7:0]  tok_dec_q, tok_dec_d;
	logic        tok_ok_q, tok_ok_d;
	logic [2:0]  oct_cnt_q, oct_cnt_d;
	logic [7:0]  oct_acc_q, oct_acc_d;
	logic        saw_dec_q, saw_dec_d;
	ipp_status_t fin_st_q, fin_st_d;
	logic        fin_v6_q, fin_v6_d;

	logic         m_tvalid_q;
	logic [127:0] m_tdata_q;
	ipp_status_t  m_tuser_q;

	logic         load;
	ipp_status_t  fst;
	logic [127:0] res_data;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// result side: gap expansion and packing
	always_comb begin
		logic [4:0] s;
		logic [7:0] sh [16];
		logic [7:0] fb [16];
		s = 5'd16 - wp_q;
		for (int k = 0; k < 16; k++) begin
			if (5'(k) < gap_pos_q) begin
				sh[k] = bytes_q[k];
			end else if (s == 5'd0 || 6'(k) < 6'(gap_pos_q) + 6'(s)) begin
				sh[k] = 8'h00;
			end else begin
				sh[k] = bytes_q[4'(5'(k) - s)];
			end
			fb[k] = (fin_v6_q && gap_seen_q) ? sh[k] : bytes_q[k];
		end
		if (fin_v6_q) begin
			fst = (gap_seen_q || wp_q == 5'd16) ? STAT_OK : STAT_INVALID;
		end else begin
			fst = fin_st_q;
		end
		res_data = '0;
		if (fst == STAT_OK) begin
			for (int i = 0; i < 8; i++) begin
				res_data[63 - 8*i -: 8]  = fb[i];
				res_data[127 - 8*i -: 8] = fb[8 + i];
			end
		end
		load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	end

	// token side
	always_comb begin
		logic [11:0] n;
		logic [11:0] t;
		logic [2:0]  oc;
		mode_t       em;
		logic        skip;
		state_d    = state_q;
		mode_d     = mode_q;
		err_d      = err_q;
		lcp_d      = lcp_q;
		bytes_d    = bytes_q;
		wp_d       = wp_q;
		gap_pos_d  = gap_pos_q;
		gap_seen_d = gap_seen_q;
		hex_acc_d  = hex_acc_q;
		saw_hex_d  = saw_hex_q;
		tok_dec_d  = tok_dec_q;
		tok_ok_d   = tok_ok_q;
		oct_cnt_d  = oct_cnt_q;
		oct_acc_d  = oct_acc_q;
		saw_dec_d  = saw_dec_q;
		fin_st_d   = fin_st_q;
		fin_v6_d   = fin_v6_q;
		pop        = 1'b0;
		n          = 12'(oct_acc_q) * 12'd10 + 12'(tok.val);
		t          = 12'(tok_dec_q) * 12'd10 + 12'(tok.val);
		oc         = saw_dec_q ? oct_cnt_q : oct_cnt_q + 3'd1;
		em         = mode_q;
		skip       = 1'b0;

		if (state_q == ST_RUN && tok_valid) begin
			pop = 1'b1;
			if (tok.nul) begin
				fin_st_d = STAT_INVALID;
				fin_v6_d = 1'b0;
				state_d  = ST_FIN;
				if (mode_q == M_IDLE) begin
					fin_st_d = (tok.fam == FAM_V4 || tok.fam == FAM_V6) ?
						STAT_INVALID : STAT_UNSUP;
				end else if (mode_q == M_UNSUP) begin
					fin_st_d = STAT_UNSUP;
				end else if (!err_q) begin
					if (mode_q == M_V4) begin
						fin_st_d = (oct_cnt_q >= 3'd4) ? STAT_OK : STAT_INVALID;
					end else if (!lcp_q) begin
						if (mode_q == M_QUAD) begin
							if (oct_cnt_q >= 3'd4) begin
								wp_d     = wp_q + 5'd4;
								fin_v6_d = 1'b1;
							end
						end else if (saw_hex_q) begin
							if (wp_q <= 5'd14) begin
								bytes_d[wp_q[3:0]]       = hex_acc_q[15:8];
								bytes_d[4'(wp_q + 5'd1)] = hex_acc_q[7:0];
								wp_d     = wp_q + 5'd2;
								fin_v6_d = 1'b1;
							end
						end else begin
							fin_v6_d = 1'b1;
						end
					end
				end
			end else begin
				if (mode_q == M_IDLE) begin
					unique case (tok.fam)
						FAM_V4: begin
							em   = M_V4;
							wp_d = 5'd12;
						end
						FAM_V6: begin
							em = M_V6;
							if (tok.colon) begin
								lcp_d = 1'b1;
								skip  = 1'b1;
							end
						end
						default: em = M_UNSUP;
					endcase
				end
				mode_d = em;
				if (!skip && !err_q && em != M_UNSUP) begin
					if (em == M_V4 || em == M_QUAD) begin
						if (tok.is_dec) begin
							if (n > 12'd255 || oc > 3'd4) begin
								err_d = 1'b1;
							end else begin
								oct_acc_d = n[7:0];
								oct_cnt_d = oc;
								saw_dec_d = 1'b1;
								bytes_d[4'(wp_d + 5'(oc) - 5'd1)] = n[7:0];
							end
						end else if (tok.dot && saw_dec_q) begin
							if (oct_cnt_q == 3'd4) begin
								err_d = 1'b1;
							end else begin
								saw_dec_d = 1'b0;
								oct_acc_d = 8'h00;
							end
						end else begin
							err_d = 1'b1;
						end
					end else if (lcp_q && !tok.colon) begin
						lcp_d = 1'b0;
						err_d = 1'b1;
					end else begin
						lcp_d = 1'b0;
						if (tok.is_hex) begin
							if (hex_acc_q[15:12] != 4'd0) begin
								err_d = 1'b1;
							end else begin
								hex_acc_d = {hex_acc_q[11:0], tok.val};
								saw_hex_d = 1'b1;
								if (tok.is_dec) begin
									if (t > 12'd255) begin
										tok_ok_d = 1'b0;
									end else begin
										tok_dec_d = t[7:0];
									end
								end else begin
									tok_ok_d = 1'b0;
								end
							end
						end else if (tok.colon) begin
							tok_dec_d = 8'h00;
							tok_ok_d  = 1'b1;
							if (!saw_hex_q) begin
								if (gap_seen_q) begin
									err_d = 1'b1;
								end else begin
									gap_seen_d = 1'b1;
									gap_pos_d  = wp_d;
								end
							end else begin
								if (wp_d > 5'd14) begin
									err_d = 1'b1;
								end else begin
									bytes_d[wp_d[3:0]]       = hex_acc_q[15:8];
									bytes_d[4'(wp_d + 5'd1)] = hex_acc_q[7:0];
									wp_d = wp_d + 5'd2;
								end
								saw_hex_d = 1'b0;
								hex_acc_d = 16'h0000;
							end
						end else if (tok.dot && wp_d <= 5'd12) begin
							if (!saw_hex_q || !tok_ok_q) begin
								err_d = 1'b1;
							end else begin
								bytes_d[wp_d[3:0]] = tok_dec_q;
								oct_cnt_d = 3'd1;
								oct_acc_d = 8'h00;
								saw_dec_d = 1'b0;
								saw_hex_d = 1'b0;
								mode_d    = M_QUAD;
							end
						end else begin
							err_d = 1'b1;
						end
					end
				end
			end
		end

		if (load) begin
			state_d    = ST_RUN;
			mode_d     = M_IDLE;
			err_d      = 1'b0;
			lcp_d      = 1'b0;
			for (int k = 0; k < 16; k++) begin
				bytes_d[k] = 8'h00;
			end
			wp_d       = 5'd0;
			gap_pos_d  = 5'd0;
			gap_seen_d = 1'b0;
			hex_acc_d  = 16'h0000;
			saw_hex_d  = 1'b0;
			tok_dec_d  = 8'h00;
			tok_ok_d   = 1'b1;
			oct_cnt_d  = 3'd0;
			oct_acc_d  = 8'h00;
			saw_dec_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			mode_q     <= M_IDLE;
			err_q      <= 1'b0;
			lcp_q      <= 1'b0;
			for (int k = 0; k < 16; k++) begin
				bytes_q[k] <= 8'h00;
			end
			wp_q       <= 5'd0;
			gap_pos_q  <= 5'd0;
			gap_seen_q <= 1'b0;
			hex_acc_q  <= 16'h0000;
			saw_hex_q  <= 1'b0;
			tok_dec_q  <= 8'h00;
			tok_ok_q   <= 1'b1;
			oct_cnt_q  <= 3'd0;
			oct_acc_q  <= 8'h00;
			saw_dec_q  <= 1'b0;
			fin_st_q   <= STAT_INVALID;
			fin_v6_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= STAT_OK;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			err_q      <= err_d;
			lcp_q      <= lcp_d;
			bytes_q    <= bytes_d;
			wp_q       <= wp_d;
			gap_pos_q  <= gap_pos_d;
			gap_seen_q <= gap_seen_d;
			hex_acc_q  <= hex_acc_d;
			saw_hex_q  <= saw_hex_d;
			tok_dec_q  <= tok_dec_d;
			tok_ok_q   <= tok_ok_d;
			oct_cnt_q  <= oct_cnt_d;
			oct_acc_q  <= oct_acc_d;
			saw_dec_q  <= saw_dec_d;
			fin_st_q   <= fin_st_d;
			fin_v6_q   <= fin_v6_d;
			if (load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= res_data;
				m_tuser_q  <= fst;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[sv/ip_address_text_parser.sv]
// Top level of the IP address text parser: classifier, token queue, parser.
// Depends on ipp_pkg, ipp_front, ipp_queue, ipp_back.
//
// Usage:
//   Input stream carries one character per transaction in s_tdata[7:0], with
//   the address family in s_tuser[1:0] (0 IPv4, 1 IPv6, other unsupported),
//   sampled at the first character of a string. A NUL character ends the
//   string and produces exactly one result transaction; other characters
//   produce none.
//   Output stream: m_tuser[1:0] is the status (0 valid, 1 invalid text,
//   2 unsupported family); m_tdata[63:0] is addr_high, m_tdata[127:64] is
//   addr_low. IPv4 addresses sit in addr_low[31:0].
//   Throughput: one character per cycle while the token queue has room;
//   after a NUL the parser takes no tokens until gap expansion has loaded
//   the result register. Result path from an accepted NUL: token queue,
//   parser finish state, then the result register.
//   When the receiver stalls, the result register holds; the token queue
//   (QDEPTH entries) keeps accepting characters until it fills, then
//   s_tready drops.
//   Reset clears the queue, all parse state and the result register.
`default_nettype none

module ip_address_text_parser
	import ipp_pkg::*;
#(
	parameter int QDEPTH = IPP_QDEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // ch
	input  wire logic [1:0]   s_tuser,   // func
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // addr_high, addr_low
	output logic [1:0]        m_tuser    // status
);

	localparam int TW = $bits(ipp_tok_t);

	ipp_tok_t        f_tok;
	ipp_tok_t        q_tok;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	logic [TW-1:0]   q_rdata;

	assign q_tok = ipp_tok_t'(q_rdata);

	ipp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.full     (q_full),
		.push     (q_push),
		.tok      (f_tok)
	);

	ipp_queue #(
		.WIDTH (TW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (f_tok),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	ipp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (!q_empty),
		.tok       (q_tok),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

[sv/ipp_checker.sv]
// Port-level checks for ip_address_text_parser, bound to the top level.
// Depends on ipp_pkg.
`default_nettype none

module ipp_checker
	import ipp_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [7:0]   s_tdata,
	input wire logic [1:0]   s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata,
	input wire logic [1:0]   m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
		else $error("failed result carries a nonzero address");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_INVALID ||
			m_tuser == STAT_UNSUP))
		else $error("undefined status code");

endmodule

bind ip_address_text_parser ipp_checker u_chk (.*);

`default_nettype wire

[tb/ip_address_text_parser_tb.sv]
`timescale 1ns / 1ps
// Testbench for ip_address_text_parser: address strings are sent one character per transaction.
// Each returned status and address is checked against an in-bench parser model.
// Depends on ipp_pkg and ip_address_text_parser.

module ip_address_text_parser_tb
	import ipp_pkg::*;
;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_CHARS = 175;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [2:0] {PM_IDLE, PM_V4, PM_V6, PM_QUAD, PM_UNSUP} parse_mode_t;

	typedef struct {
		logic [7:0] ch;
		logic [1:0] fam;
	} char_item_t;

	typedef struct {
		ipp_status_t status;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;   // ch
	logic [1:0] s_tuser;   // func
	logic m_tvalid;
	logic m_tready;
	logic [127:0] m_tdata; // addr_high, addr_low
	logic [1:0] m_tuser;   // status

	ip_address_text_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	parse_mode_t pm;
	bit          bad;
	bit          lead_colon;
	logic [7:0]  abuf [16];
	int unsigned wpos;
	int unsigned gpos;
	bit          gap_on;
	logic [15:0] hacc;
	bit          hex_any;
	logic [7:0]  tdec;
	bit          tdec_ok;
	int unsigned n_oct;
	logic [7:0]  oacc;
	bit          dec_any;

	parse_result_t parse_expect_q[$];
	char_item_t    pend_q[$];
	logic [7:0]    txt[$];
	string         noise_set = "0123456789abcdefABCDEF:.";

	char_item_t    next_char;
	parse_result_t want;
	bit            char_taken;
	int            tx_idle_pct;
	int            rx_idle_pct;
	int            n_miss;
	int            n_results;
	int            n_chars_queued;
	int            n_strings;
	int            n_stat [3];
	int            idle_cycles;

	function automatic void clear_parse();
		pm = PM_IDLE;
		bad = 0;
		lead_colon = 0;
		foreach (abuf[i]) abuf[i] = 8'h00;
		wpos = 0;
		gpos = 0;
		gap_on = 0;
		hacc = 16'h0000;
		hex_any = 0;
		tdec = 8'h00;
		tdec_ok = 1;
		n_oct = 0;
		oacc = 8'h00;
		dec_any = 0;
	endfunction

	function automatic int hex_val(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
		if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
		if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
		return -1;
	endfunction

	function automatic void quad_char(logic [7:0] c);
		int unsigned n;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			n = oacc * 10 + (c - CH_ZERO);
			if (n > 255) begin
				bad = 1;
				return;
			end
			oacc = n[7:0];
			if (!dec_any) begin
				n_oct++;
				if (n_oct > 4) begin
					bad = 1;
					return;
				end
				dec_any = 1;
			end
			abuf[(wpos + n_oct - 1) & 15] = n[7:0];
		end else if (c == CH_DOT && dec_any) begin
			if (n_oct == 4) begin
				bad = 1;
				return;
			end
			dec_any = 0;
			oacc = 8'h00;
		end else begin
			bad = 1;
		end
	endfunction

	function automatic void put_group();
		if (wpos + 2 > 16) begin
			bad = 1;
			return;
		end
		abuf[wpos & 15] = hacc[15:8];
		abuf[(wpos + 1) & 15] = hacc[7:0];
		wpos = wpos + 2;
	endfunction

	function automatic void v6_char(logic [7:0] c);
		int d;
		int unsigned v;
		int unsigned t;
		d = hex_val(c);
		if (d >= 0) begin
			v = (hacc << 4) | d;
			if (v > 32'hffff) begin
				bad = 1;
				return;
			end
			hacc = v[15:0];
			hex_any = 1;
			if (c <= CH_NINE) begin
				t = tdec * 10 + d;
				if (t > 255) tdec_ok = 0;
				else tdec = t[7:0];
			end else begin
				tdec_ok = 0;
			end
			return;
		end
		if (c == CH_COLON) begin
			tdec = 8'h00;
			tdec_ok = 1;
			if (!hex_any) begin
				if (gap_on) begin
					bad = 1;
					return;
				end
				gap_on = 1;
				gpos = wpos;
				return;
			end
			put_group();
			hex_any = 0;
			hacc = 16'h0000;
			return;
		end
		if (c == CH_DOT && wpos + 4 <= 16) begin
			if (!hex_any || !tdec_ok) begin
				bad = 1;
				return;
			end
			abuf[wpos & 15] = tdec;
			n_oct = 1;
			oacc = 8'h00;
			dec_any = 0;
			hex_any = 0;
			pm = PM_QUAD;
			return;
		end
		bad = 1;
	endfunction

	function automatic bit v6_close();
		int unsigned len;
		int unsigned src;
		if (lead_colon) return 0;
		if (pm == PM_QUAD) begin
			if (n_oct < 4) return 0;
			wpos = wpos + 4;
		end else if (hex_any) begin
			put_group();
			if (bad) return 0;
		end
		if (gap_on) begin
			len = (wpos - gpos) & 31;
			if (len > 16) len = 16;
			for (int unsigned i = 1; i <= len; i++) begin
				src = (gpos + len - i) & 15;
				abuf[(16 - i) & 15] = abuf[src];
				abuf[src] = 8'h00;
			end
			wpos = 16;
		end
		return wpos == 16;
	endfunction

	function automatic void parse_char(logic [7:0] c, logic [1:0] fam);
		parse_result_t res;
		bit ok;
		if (c == CH_NUL) begin
			res.status = STAT_INVALID;
			res.addr_high = 64'h0;
			res.addr_low = 64'h0;
			ok = 0;
			if (pm == PM_IDLE) begin
				res.status = (fam == FAM_V4 || fam == FAM_V6) ? STAT_INVALID : STAT_UNSUP;
			end else if (pm == PM_UNSUP) begin
				res.status = STAT_UNSUP;
			end else if (!bad) begin
				if (pm == PM_V4) ok = (n_oct >= 4);
				else ok = v6_close();
				res.status = ok ? STAT_OK : STAT_INVALID;
			end
			if (ok) begin
				for (int i = 0; i < 8; i++) begin
					res.addr_high = {res.addr_high[55:0], abuf[i]};
					res.addr_low = {res.addr_low[55:0], abuf[i + 8]};
				end
			end
			n_stat[res.status]++;
			parse_expect_q.push_back(res);
			clear_parse();
			return;
		end
		if (pm == PM_IDLE) begin
			if (fam == FAM_V4) begin
				pm = PM_V4;
				wpos = 12;
			end else if (fam == FAM_V6) begin
				pm = PM_V6;
				if (c == CH_COLON) begin
					lead_colon = 1;
					return;
				end
			end else begin
				pm = PM_UNSUP;
			end
		end
		if (bad || pm == PM_UNSUP) return;
		if (pm == PM_V4 || pm == PM_QUAD) begin
			quad_char(c);
		end else begin
			if (lead_colon) begin
				lead_colon = 0;
				if (c != CH_COLON) begin
					bad = 1;
					return;
				end
			end
			v6_char(c);
		end
	endfunction

	// stimulus text builders
	function automatic void add_char(logic [7:0] c);
		if (c >= CH_LA && c <= CH_LF && $urandom_range(1) == 1) c = c - CASE_BIT;
		txt.push_back(c);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i]);
	endfunction

	function automatic void add_num(int unsigned v, int unsigned base, int unsigned ndig);
		logic [7:0] d[$];
		int unsigned x;
		x = v;
		do begin
			d.push_front(8'((x % base < 10) ? CH_ZERO + x % base : CH_LA + x % base - 10));
			x = x / base;
		end while (x != 0);
		while (d.size() < ndig) d.push_front(CH_ZERO);
		foreach (d[i]) add_char(d[i]);
	endfunction

	function automatic void add_quad(int unsigned n);
		int unsigned r;
		for (int unsigned k = 0; k < n; k++) begin
			if (k > 0) add_text(".");
			r = $urandom_range(19);
			case (r)
				0: add_num($urandom_range(999, 256), 10, 0);
				1: add_num($urandom_range(255), 10, 3);
				2: add_num(255, 10, 0);
				3: add_num(0, 10, 0);
				default: add_num($urandom_range(255), 10, 0);
			endcase
		end
	endfunction

	function automatic void add_group();
		case ($urandom_range(9))
			0: add_num(16'hffff, 16, 0);
			1: add_num(0, 16, 0);
			2: add_num($urandom_range(20'hfffff), 16, 5);
			3: add_num($urandom_range(16'hffff), 16, 4);
			default: add_num($urandom_range(16'hffff) >> (4 * $urandom_range(3)), 16, 0);
		endcase
	endfunction

	function automatic void add_v6();
		int unsigned slots;
		int unsigned nhex;
		int unsigned left;
		int unsigned right;
		int unsigned r;
		bit gap;
		bit quad;
		gap = ($urandom_range(1) == 1);
		quad = ($urandom_range(3) == 0);
		r = $urandom_range(9);
		if (gap) slots = (r == 0) ? 8 : $urandom_range(7);
		else slots = (r == 0) ? 7 : (r == 1) ? 9 : 8;
		if (slots < 2) quad = 0;
		nhex = quad ? slots - 2 : slots;
		left = gap ? $urandom_range(nhex) : nhex;
		right = nhex - left;
		for (int unsigned k = 0; k < left; k++) begin
			if (k > 0) add_text(":");
			add_group();
		end
		if (gap) add_text("::");
		else if (left > 0 && quad) add_text(":");
		for (int unsigned k = 0; k < right; k++) begin
			if (k > 0) add_text(":");
			add_group();
		end
		if (quad) begin
			if (right > 0) add_text(":");
			add_quad(($urandom_range(7) == 0) ? 3 : 4);
		end else if ($urandom_range(7) == 0) begin
			add_text(($urandom_range(1) == 1) ? "::" : ":");
		end
	endfunction

	function automatic logic [7:0] noise_char();
		if ($urandom_range(3) == 0) return 8'($urandom_range(255, 1));
		return noise_set[$urandom_range(noise_set.len() - 1)];
	endfunction

	function automatic void send_string(logic [1:0] fam);
		char_item_t it;
		foreach (txt[i]) begin
			it.ch = txt[i];
			if (i == 0 || $urandom_range(3) != 0) it.fam = fam;
			else it.fam = 2'($urandom_range(3));
			pend_q.push_back(it);
		end
		it.ch = CH_NUL;
		if (txt.size() == 0 || $urandom_range(1) == 0) it.fam = fam;
		else it.fam = 2'($urandom_range(3));
		pend_q.push_back(it);
		n_chars_queued += txt.size() + 1;
		n_strings++;
		txt.delete();
	endfunction

	function automatic void random_string();
		int unsigned r;
		int unsigned k;
		logic [1:0] fam;
		r = $urandom_range(99);
		if (r < 35) begin
			fam = FAM_V4;
			k = $urandom_range(9);
			add_quad((k == 0) ? 3 : (k == 1) ? 5 : 4);
		end else if (r < 80) begin
			fam = FAM_V6;
			add_v6();
		end else begin
			fam = 2'($urandom_range(3));
			k = $urandom_range(8);
			repeat (k) txt.push_back(noise_char());
		end
		if (r < 80 && txt.size() > 0 && $urandom_range(9) == 0) begin
			k = $urandom_range(txt.size() - 1);
			if ($urandom_range(1) == 1) txt[k] = noise_char();
			else while (txt.size() > k) void'(txt.pop_back());
		end
		if (r < 80 && $urandom_range(19) == 0) fam = 2'($urandom_range(3));
		send_string(fam);
	endfunction

	function automatic void report_miss(string field, logic [63:0] exp_val, logic [63:0] got);
		n_miss++;
		if (n_miss <= 10)
			$display("MISMATCH result %0d %s: expected %h, got %h", n_results, field,
				exp_val, got);
	endfunction

	// driver: new transaction offered at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
			if (!s_tvalid || char_taken) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_char = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_char.ch;
					s_tuser <= next_char.fam;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			char_taken = 0;
		end
	end

	// monitor: both sides sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			parse_char(s_tdata, s_tuser);
			char_taken = 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (parse_expect_q.size() == 0) begin
				n_miss++;
				if (n_miss <= 10)
					$display("MISMATCH unexpected result %0d: status %0d, data %h",
						n_results, m_tuser, m_tdata);
			end else begin
				want = parse_expect_q.pop_front();
				if (m_tuser !== want.status) report_miss("status", want.status, m_tuser);
				if (m_tdata[63:0] !== want.addr_high)
					report_miss("addr_high", want.addr_high, m_tdata[63:0]);
				if (m_tdata[127:64] !== want.addr_low)
					report_miss("addr_low", want.addr_low, m_tdata[127:64]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, parse_expect_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int start;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 2'b00;
		m_tready = 1'b0;
		char_taken = 0;
		n_miss = 0;
		n_results = 0;
		n_chars_queued = 0;
		n_strings = 0;
		idle_cycles = 0;
		foreach (n_stat[i]) n_stat[i] = 0;
		clear_parse();
		tx_idle_pct = 18;
		rx_idle_pct = 66;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty strings, unsupported family, leading colon, bare gap, extremes
		send_string(FAM_V4);
		send_string(2'd2);
		txt.push_back(8'hff);
		send_string(2'd3);
		add_text(":1");
		send_string(FAM_V6);
		add_text("::");
		send_string(FAM_V6);
		add_text("255.0.0.1");
		send_string(FAM_V4);
		add_text("::f");
		send_string(FAM_V6);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				tx_idle_pct = 66;
				rx_idle_pct = 18;
			end else if (ph == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			start = n_chars_queued;
			while (n_chars_queued - start < PHASE_CHARS) random_string();
			wait (pend_q.size() == 0);
		end

		wait (pend_q.size() == 0 && !s_tvalid);
		wait (parse_expect_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d strings in %0d characters; checked %0d results", n_strings,
			n_chars_queued, n_results);
		$display("Predicted %0d valid, %0d invalid, %0d unsupported; %0d mismatches",
			n_stat[STAT_OK], n_stat[STAT_INVALID], n_stat[STAT_UNSUP], n_miss);
		if (n_miss == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
